[design/lht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lht_pkg: shared types for the LRU handle table
// Command codes, controller states, and the command/status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package lht_pkg;

  localparam int unsigned CmdW = 2;
  localparam int unsigned CfgW = 5;
  localparam int unsigned DataW = 64;
  localparam logic [CfgW-1:0] MaxCachedReset = 5'd16;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_PEEK   = 2'd3
  } cmd_e;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_ACT    = 8'b0000_0100,
    S_PLACE  = 8'b0000_1000,
    S_TRIM   = 8'b0001_0000,
    S_EVRD   = 8'b0010_0000,
    S_EVOUT  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch item fields, restart scan
    logic scan;       // step the key search
    logic drop_slot;  // remove the matched entry
    logic touch;      // make the matched entry most recent
    logic place;      // write the new entry into a free slot
    logic evict;      // drop LRU entry, read its key
    logic emit_ev;    // send an eviction result
    logic emit_last;  // send the closing result
  } lht_ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic match;       // key compare hit this cycle
    logic scan_end;    // final entry compared
    logic found;       // a match was captured for this item
    logic limit_zero;  // caching disabled
    logic full;        // every slot valid
    logic over_limit;  // count above max_cached
  } lht_stat_t;

endpackage : lht_pkg
`default_nettype wire

[design/lht_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lht_ctrl: sequencing state machine for the LRU handle table
// Runs search, update, placement and eviction steps for one item at a time.
// ----------------------------------------------------------------------------
module lht_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire lht_pkg::lht_stat_t stat_i,
  output lht_pkg::lht_ctl_t      ctl_o
);

  lht_pkg::state_e state_q, state_d;
  logic placed_q, placed_d;

  always_comb begin
    state_d  = state_q;
    placed_d = placed_q;
    ctl_o    = '0;
    case (state_q)
      lht_pkg::S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          placed_d   = 1'b0;
          state_d    = lht_pkg::S_SCAN;
        end
      end
      lht_pkg::S_SCAN: begin
        ctl_o.scan = 1'b1;
        if (stat_i.match || stat_i.scan_end) begin
          state_d = lht_pkg::S_ACT;
        end
      end
      lht_pkg::S_ACT: begin
        state_d = lht_pkg::S_FINISH;
        case (stat_i.cmd)
          lht_pkg::CMD_INSERT: begin
            if (!stat_i.limit_zero) begin
              ctl_o.drop_slot = stat_i.found;
              state_d         = lht_pkg::S_PLACE;
            end
          end
          lht_pkg::CMD_REMOVE: ctl_o.drop_slot = stat_i.found;
          lht_pkg::CMD_LOOKUP: ctl_o.touch = stat_i.found;
          default: ;
        endcase
      end
      lht_pkg::S_PLACE: begin
        if (stat_i.full) begin
          state_d = lht_pkg::S_EVRD;
        end else begin
          ctl_o.place = 1'b1;
          placed_d    = 1'b1;
          state_d     = lht_pkg::S_TRIM;
        end
      end
      lht_pkg::S_TRIM: begin
        state_d = stat_i.over_limit ? lht_pkg::S_EVRD : lht_pkg::S_FINISH;
      end
      lht_pkg::S_EVRD: begin
        ctl_o.evict = 1'b1;
        state_d     = lht_pkg::S_EVOUT;
      end
      lht_pkg::S_EVOUT: begin
        ctl_o.emit_ev = 1'b1;
        state_d       = placed_q ? lht_pkg::S_TRIM : lht_pkg::S_PLACE;
      end
      lht_pkg::S_FINISH: begin
        ctl_o.emit_last = 1'b1;
        state_d         = lht_pkg::S_IDLE;
      end
      default: state_d = lht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lht_pkg::S_IDLE;
      placed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      placed_q <= placed_d;
    end
  end

  assign busy = (state_q != lht_pkg::S_IDLE);

endmodule : lht_ctrl
`default_nettype wire

[design/lht_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lht_dpath: storage and update logic for the LRU handle table
// Key/layout memory with a pipelined search port, per-entry valid and
// recency rank registers, entry count, capacity register and result regs.
// ----------------------------------------------------------------------------
module lht_dpath #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lht_pkg::lht_ctl_t            ctl_i,
  output lht_pkg::lht_stat_t                stat_o,
  input  wire logic [lht_pkg::CmdW-1:0]     cmd_i,
  input  wire logic [lht_pkg::DataW-1:0]    handle_i,
  input  wire logic [lht_pkg::DataW-1:0]    layout_in_i,
  input  wire logic                         max_cached_we_i,
  input  wire logic [lht_pkg::CfgW-1:0]     max_cached_i,
  output logic                              result_valid_o,
  output logic                              hit_o,
  output logic [lht_pkg::DataW-1:0]         layout_out_o,
  output logic                              evicted_o,
  output logic [lht_pkg::DataW-1:0]         evicted_handle_o,
  output logic                              last_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned LW = (CW > lht_pkg::CfgW) ? CW : lht_pkg::CfgW;
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);
  localparam logic [CW-1:0] Full = CW'(ENTRIES);

  // item fields
  lht_pkg::cmd_e               cmd_q;
  logic [lht_pkg::DataW-1:0]   handle_q;
  logic [lht_pkg::DataW-1:0]   layout_q;
  logic [lht_pkg::CfgW-1:0]    max_cached_q;

  // storage
  logic [lht_pkg::DataW-1:0]   key_mem [ENTRIES];
  logic [lht_pkg::DataW-1:0]   lay_mem [ENTRIES];
  logic [lht_pkg::DataW-1:0]   rd_key_q, rd_lay_q;
  logic [ENTRIES-1:0]          valid_q;
  logic [IW-1:0]               rank_q [ENTRIES];
  logic [CW-1:0]               count_q;

  // search
  logic [IW-1:0]               scan_q, rd_idx_q, slot_q;
  logic                        rd_vld_q, found_q;
  logic [lht_pkg::DataW-1:0]   hit_lay_q;
  logic                        match;

  // result registers
  logic                        res_valid_q, hit_q, evicted_q, last_q;
  logic [lht_pkg::DataW-1:0]   res_lay_q, res_evh_q;

  logic [IW-1:0]               vict_idx, free_idx, drop_idx, raddr;
  logic                        vict_ok, free_ok;
  logic [IW-1:0]               lru_rank, drop_rank, touch_rank;

  assign lru_rank = IW'(count_q - CW'(1));

  // LRU victim and first free slot, both priority encoded
  always_comb begin
    vict_idx = '0;
    vict_ok  = 1'b0;
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!vict_ok && valid_q[i] && rank_q[i] == lru_rank) begin
        vict_idx = IW'(i);
        vict_ok  = 1'b1;
      end
      if (!free_ok && !valid_q[i]) begin
        free_idx = IW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  assign drop_idx   = ctl_i.evict ? vict_idx : slot_q;
  assign drop_rank  = rank_q[drop_idx];
  assign touch_rank = rank_q[slot_q];
  assign raddr      = ctl_i.evict ? vict_idx : scan_q;

  assign match = rd_vld_q && valid_q[rd_idx_q] && (rd_key_q == handle_q);

  // key/layout memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.place) begin
      key_mem[free_idx] <= handle_q;
      lay_mem[free_idx] <= layout_q;
    end
    rd_key_q <= key_mem[raddr];
    rd_lay_q <= lay_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cached_q <= lht_pkg::MaxCachedReset;
    end else if (max_cached_we_i) begin
      max_cached_q <= max_cached_i;
    end
  end

  // item capture and search pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= lht_pkg::CMD_INSERT;
      handle_q <= '0;
      layout_q <= '0;
      scan_q   <= '0;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      slot_q   <= '0;
    end else begin
      rd_vld_q <= ctl_i.scan;
      if (ctl_i.load) begin
        cmd_q    <= lht_pkg::cmd_e'(cmd_i);
        handle_q <= handle_i;
        layout_q <= layout_in_i;
        scan_q   <= '0;
        found_q  <= 1'b0;
      end else if (ctl_i.scan) begin
        scan_q   <= scan_q + IW'(1);
        rd_idx_q <= scan_q;
        if (match) begin
          found_q <= 1'b1;
          slot_q  <= rd_idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.scan && match) begin
      hit_lay_q <= rd_lay_q;
    end
  end

  // valid bits, recency ranks (0 = most recent) and entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (ctl_i.drop_slot || ctl_i.evict) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && rank_q[i] > drop_rank) begin
          rank_q[i] <= rank_q[i] - IW'(1);
        end
      end
      valid_q[drop_idx] <= 1'b0;
      count_q           <= count_q - CW'(1);
    end else if (ctl_i.touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && rank_q[i] < touch_rank) begin
          rank_q[i] <= rank_q[i] + IW'(1);
        end
      end
      rank_q[slot_q] <= '0;
    end else if (ctl_i.place) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i]) begin
          rank_q[i] <= rank_q[i] + IW'(1);
        end
      end
      rank_q[free_idx]  <= '0;
      valid_q[free_idx] <= 1'b1;
      count_q           <= count_q + CW'(1);
    end
  end

  // result registers: each result is shown for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctl_i.emit_ev || ctl_i.emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_ev) begin
      hit_q     <= 1'b0;
      res_lay_q <= '0;
      evicted_q <= 1'b1;
      res_evh_q <= rd_key_q;
      last_q    <= 1'b0;
    end else if (ctl_i.emit_last) begin
      hit_q     <= found_q && (cmd_q == lht_pkg::CMD_LOOKUP ||
                               cmd_q == lht_pkg::CMD_PEEK);
      res_lay_q <= (found_q && (cmd_q == lht_pkg::CMD_LOOKUP ||
                                cmd_q == lht_pkg::CMD_PEEK)) ? hit_lay_q : '0;
      evicted_q <= 1'b0;
      res_evh_q <= '0;
      last_q    <= 1'b1;
    end
  end

  assign result_valid_o   = res_valid_q;
  assign hit_o            = hit_q;
  assign layout_out_o     = res_lay_q;
  assign evicted_o        = evicted_q;
  assign evicted_handle_o = res_evh_q;
  assign last_o           = last_q;

  always_comb begin
    stat_o            = '0;
    stat_o.cmd        = cmd_q;
    stat_o.match      = match;
    stat_o.scan_end   = rd_vld_q && (rd_idx_q == LastIdx);
    stat_o.found      = found_q;
    stat_o.limit_zero = (max_cached_q == '0);
    stat_o.full       = (count_q == Full);
    stat_o.over_limit = (LW'(count_q) > LW'(max_cached_q));
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count above table size");

  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count out of step with valid bits");

  a_place_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.place |-> (free_ok && count_q != Full))
    else $error("placement into a full table");

  a_evict_lru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.evict |-> (vict_ok && count_q != '0))
    else $error("eviction without a least recent entry");

endmodule : lht_dpath
`default_nettype wire

[design/lru_handle_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// A lookup, peek or remove shows its one result once the key search ends; the search
//   compares one entry per cycle and stops at a hit or after the last entry.
// An insert also places its entry unless max_cached is 0, and evicts LRU entries as needed.
// Throughput: one item at a time; a new item is taken in the cycle its predecessor's
//   last result is shown. Results cannot be stalled by the receiver.
// Reset: table empty, max_cached = 16; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
// lru_handle_table: fully associative LRU table of 64-bit handles
// Stores a layout word per handle; insert, remove, lookup and peek commands,
// with one result per eviction and a closing result per item.
// ----------------------------------------------------------------------------
module lru_handle_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [lht_pkg::CmdW-1:0]  cmd_i,
  input  wire logic [lht_pkg::DataW-1:0] handle_i,
  input  wire logic [lht_pkg::DataW-1:0] layout_in_i,
  input  wire logic                      max_cached_we_i,
  input  wire logic [lht_pkg::CfgW-1:0]  max_cached_i,
  output logic                           result_valid_o,
  output logic                           hit_o,
  output logic [lht_pkg::DataW-1:0]      layout_out_o,
  output logic                           evicted_o,
  output logic [lht_pkg::DataW-1:0]      evicted_handle_o,
  output logic                           last_o
);

  lht_pkg::lht_ctl_t  ctl;
  lht_pkg::lht_stat_t stat;

  lht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  lht_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .stat_o           (stat),
    .cmd_i            (cmd_i),
    .handle_i         (handle_i),
    .layout_in_i      (layout_in_i),
    .max_cached_we_i  (max_cached_we_i),
    .max_cached_i     (max_cached_i),
    .result_valid_o   (result_valid_o),
    .hit_o            (hit_o),
    .layout_out_o     (layout_out_o),
    .evicted_o        (evicted_o),
    .evicted_handle_o (evicted_handle_o),
    .last_o           (last_o)
  );

endmodule : lru_handle_table
`default_nettype wire
